/* rtl/pprs_pkg.sv */
package pprs_pkg;

    // Default field widths
    localparam int COEF_BITS_DEF  = 16;
    localparam int COORD_BITS_DEF = 16;

    // Register file layout
    localparam int DATA_BITS   = 64;
    localparam int ADDR_BITS   = 6;
    localparam int IDX_LSB     = 3;
    localparam int IDX_BITS    = 3;
    localparam int COEF_STRIDE = 16;
    localparam int ROW_COEFS   = 4;
    localparam int CORNER_BITS = 12;
    localparam int RECT_BITS   = 2 * CORNER_BITS;
    localparam int SIZE_BITS   = 13;
    localparam int SCREEN_BITS = 2 * SIZE_BITS;

    // Pipeline depth from request to result strobe
    localparam int LATENCY = 5;

    localparam logic [DATA_BITS-1:0]   ROW_X_RST  = 64'h0000_0000_0000_1000;
    localparam logic [DATA_BITS-1:0]   ROW_Y_RST  = 64'h0000_0000_1000_0000;
    localparam logic [DATA_BITS-1:0]   ROW_W_RST  = 64'h1000_0000_0000_0000;
    localparam logic [RECT_BITS-1:0]   RECT_RST   = '0;
    localparam logic [SCREEN_BITS-1:0] SCREEN_RST = 26'd8849280;

    typedef enum logic [IDX_BITS-1:0] {
        REG_ROW_X  = 3'd0,
        REG_ROW_Y  = 3'd1,
        REG_ROW_W  = 3'd2,
        REG_RECT_X = 3'd3,
        REG_RECT_Y = 3'd4,
        REG_SCREEN = 3'd5
    } t_reg_idx;

endpackage

/* rtl/pprs_row.sv */
module pprs_row #(
    parameter int COEF_BITS  = pprs_pkg::COEF_BITS_DEF,
    parameter int COORD_BITS = pprs_pkg::COORD_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic [pprs_pkg::DATA_BITS-1:0]                i_coeffs,
    input  logic signed [COORD_BITS-1:0]                  i_point_x,
    input  logic signed [COORD_BITS-1:0]                  i_point_y,
    input  logic signed [COORD_BITS-1:0]                  i_point_z,
    output logic signed [COEF_BITS+COORD_BITS+1:0]        o_sum
);
    import pprs_pkg::*;

    localparam int PROD_W     = COEF_BITS + COORD_BITS;
    localparam int SUM_W      = PROD_W + 2;
    localparam int COORD_FRAC = COORD_BITS / 2;

    logic signed [COEF_BITS-1:0]  coef [ROW_COEFS];
    logic signed [COORD_BITS-1:0] coord [3];
    logic signed [PROD_W-1:0]     r_prod [3];
    logic signed [PROD_W-1:0]     r_bias;
    logic signed [SUM_W-1:0]      r_sum;

    always_comb begin
        for (int k = 0; k < ROW_COEFS; k++) begin
            coef[k] = i_coeffs[COEF_STRIDE*k +: COEF_BITS];
        end
        coord[0] = i_point_x;
        coord[1] = i_point_y;
        coord[2] = i_point_z;
    end

    // Stage one: three lane products, constant term lined up with them
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= PROD_W'(coef[k]) * PROD_W'(coord[k]);
        end
        r_bias <= PROD_W'(coef[3]) <<< COORD_FRAC;
    end

    // Stage two: add the row
    always_ff @(posedge i_clk) begin
        r_sum <= SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2]) + SUM_W'(r_bias);
    end

    assign o_sum = r_sum;

endmodule

/* rtl/point_project_rect_select.sv */
// Rectangle pick test for a stream of 3D points. Each request carries one
// point (signed fixed-point x, y, z) and its prior selection mark; the point is
// projected through the x, y and w rows of the configured matrix and tested,
// bounds included, against the pixel rectangle mapped to normalised screen
// space (y axis flipped). All tests are exact cross-multiplied integer compares.
// A point with w of zero is never inside. One request is taken every clock
// (busy stays low) and its result appears on o_done after one register stage
// each for lane products, row sums, sign fold, scaling multipliers and the
// bound compare. The result strobe cannot be held off, so the receiver must
// take every result in the cycle it is shown. Registers sit at byte addresses
// 8*i of the APB port and should be written only while no request is in
// flight.
module point_project_rect_select #(
    parameter int COEF_BITS  = pprs_pkg::COEF_BITS_DEF,
    parameter int COORD_BITS = pprs_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_BITS-1:0]      i_point_x,
    input  logic signed [COORD_BITS-1:0]      i_point_y,
    input  logic signed [COORD_BITS-1:0]      i_point_z,
    input  logic                              i_prior_mark,
    // result channel
    output logic                              o_done,
    output logic                              o_new_mark,
    output logic                              o_inside_rect,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pprs_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [pprs_pkg::DATA_BITS-1:0]    pwdata,
    output logic [pprs_pkg::DATA_BITS-1:0]    prdata,
    output logic                              pready
);
    import pprs_pkg::*;

    localparam int SUM_W = COEF_BITS + COORD_BITS + 2;   // projected row value
    localparam int NUM_W = SUM_W + 1;                    // row value plus w
    localparam int LIM_W = SIZE_BITS + 2;                // doubled signed bound
    localparam int SC_W  = SUM_W + 16;                   // scaled compare operands

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DATA_BITS-1:0]   r_row_x;
    logic [DATA_BITS-1:0]   r_row_y;
    logic [DATA_BITS-1:0]   r_row_w;
    logic [RECT_BITS-1:0]   r_rect_x;
    logic [RECT_BITS-1:0]   r_rect_y;
    logic [SCREEN_BITS-1:0] r_screen;

    t_reg_idx reg_idx;
    logic     cfg_write;

    assign reg_idx   = t_reg_idx'(paddr[IDX_LSB +: IDX_BITS]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x  <= ROW_X_RST;
            r_row_y  <= ROW_Y_RST;
            r_row_w  <= ROW_W_RST;
            r_rect_x <= RECT_RST;
            r_rect_y <= RECT_RST;
            r_screen <= SCREEN_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_ROW_X:  r_row_x  <= pwdata;
                REG_ROW_Y:  r_row_y  <= pwdata;
                REG_ROW_W:  r_row_w  <= pwdata;
                REG_RECT_X: r_rect_x <= pwdata[RECT_BITS-1:0];
                REG_RECT_Y: r_rect_y <= pwdata[RECT_BITS-1:0];
                REG_SCREEN: r_screen <= pwdata[SCREEN_BITS-1:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ROW_X:  prdata = r_row_x;
            REG_ROW_Y:  prdata = r_row_y;
            REG_ROW_W:  prdata = r_row_w;
            REG_RECT_X: prdata = DATA_BITS'(r_rect_x);
            REG_RECT_Y: prdata = DATA_BITS'(r_rect_y);
            REG_SCREEN: prdata = DATA_BITS'(r_screen);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Rectangle bounds, derived from static configuration
    // ------------------------------------------------------------------
    logic [SIZE_BITS-1:0]          size_w;
    logic [SIZE_BITS-1:0]          size_h;
    logic [SIZE_BITS-1:0]          span_w;   // width - 1
    logic [SIZE_BITS-1:0]          span_h;   // height - 1
    logic [CORNER_BITS-1:0]        xc_a, xc_b, yc_a, yc_b;
    logic [CORNER_BITS-1:0]        x_lo, x_hi;
    logic signed [SIZE_BITS:0]     y_a, y_b, y_lo, y_hi;
    logic signed [LIM_W-1:0]       lim_x_lo, lim_x_hi, lim_y_lo, lim_y_hi;

    always_comb begin
        size_w = r_screen[SIZE_BITS-1:0];
        size_h = r_screen[SCREEN_BITS-1:SIZE_BITS];
        // take a screen edge below two pixels as two
        if (size_w < SIZE_BITS'(2)) size_w = SIZE_BITS'(2);
        if (size_h < SIZE_BITS'(2)) size_h = SIZE_BITS'(2);
        span_w = size_w - SIZE_BITS'(1);
        span_h = size_h - SIZE_BITS'(1);

        xc_a = r_rect_x[CORNER_BITS-1:0];
        xc_b = r_rect_x[RECT_BITS-1:CORNER_BITS];
        yc_a = r_rect_y[CORNER_BITS-1:0];
        yc_b = r_rect_y[RECT_BITS-1:CORNER_BITS];

        x_lo = (xc_a < xc_b) ? xc_a : xc_b;
        x_hi = (xc_a < xc_b) ? xc_b : xc_a;

        // flip the y axis: bound becomes (height-1) - corner
        y_a  = $signed({1'b0, span_h}) - $signed({2'b00, yc_a});
        y_b  = $signed({1'b0, span_h}) - $signed({2'b00, yc_b});
        y_lo = (y_a < y_b) ? y_a : y_b;
        y_hi = (y_a < y_b) ? y_b : y_a;

        // bounds doubled to absorb the 0.5 scale of the point
        lim_x_lo = $signed({2'b00, x_lo, 1'b0});
        lim_x_hi = $signed({2'b00, x_hi, 1'b0});
        lim_y_lo = $signed({y_lo, 1'b0});
        lim_y_hi = $signed({y_hi, 1'b0});
    end

    // ------------------------------------------------------------------
    // Stages one and two: project through the three rows
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] proj_x, proj_y, proj_w;

    pprs_row #(.COEF_BITS(COEF_BITS), .COORD_BITS(COORD_BITS)) u_row_x (
        .i_clk     (i_clk),
        .i_coeffs  (r_row_x),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .o_sum     (proj_x)
    );

    pprs_row #(.COEF_BITS(COEF_BITS), .COORD_BITS(COORD_BITS)) u_row_y (
        .i_clk     (i_clk),
        .i_coeffs  (r_row_y),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .o_sum     (proj_y)
    );

    pprs_row #(.COEF_BITS(COEF_BITS), .COORD_BITS(COORD_BITS)) u_row_w (
        .i_clk     (i_clk),
        .i_coeffs  (r_row_w),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .o_sum     (proj_w)
    );

    // Valid bits and the prior mark travel alongside the row units
    logic r1_valid, r2_valid, r3_valid, r4_valid;
    logic r1_prior, r2_prior, r3_prior, r4_prior;

    // never stalls: a request is taken in every cycle
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            o_done   <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            o_done   <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prior <= i_prior_mark;
        r2_prior <= r1_prior;
        r3_prior <= r2_prior;
        r4_prior <= r3_prior;
    end

    // ------------------------------------------------------------------
    // Stage three: fold the sign of w, add w to the x and y numerators
    // ------------------------------------------------------------------
    logic                    w_neg;
    logic signed [SUM_W-1:0] fx, fy, fw;

    logic                    r3_w_zero;
    logic signed [SUM_W-1:0] r3_w_abs;
    logic signed [NUM_W-1:0] r3_num_x, r3_num_y;

    always_comb begin
        w_neg = proj_w[SUM_W-1];
        fx    = w_neg ? -proj_x : proj_x;
        fy    = w_neg ? -proj_y : proj_y;
        fw    = w_neg ? -proj_w : proj_w;
    end

    always_ff @(posedge i_clk) begin
        r3_w_zero <= (proj_w == '0);
        r3_w_abs  <= fw;
        r3_num_x  <= NUM_W'(fx) + NUM_W'(fw);
        r3_num_y  <= NUM_W'(fy) + NUM_W'(fw);
    end

    // ------------------------------------------------------------------
    // Stage four: scale numerators by the screen span, w by the bounds
    // ------------------------------------------------------------------
    logic                   r4_w_zero;
    logic signed [SC_W-1:0] r4_lhs_x, r4_lhs_y;
    logic signed [SC_W-1:0] r4_x_lo, r4_x_hi, r4_y_lo, r4_y_hi;

    always_ff @(posedge i_clk) begin
        r4_w_zero <= r3_w_zero;
        r4_lhs_x  <= SC_W'(r3_num_x) * SC_W'($signed({1'b0, span_w}));
        r4_lhs_y  <= SC_W'(r3_num_y) * SC_W'($signed({1'b0, span_h}));
        r4_x_lo   <= SC_W'(r3_w_abs) * SC_W'(lim_x_lo);
        r4_x_hi   <= SC_W'(r3_w_abs) * SC_W'(lim_x_hi);
        r4_y_lo   <= SC_W'(r3_w_abs) * SC_W'(lim_y_lo);
        r4_y_hi   <= SC_W'(r3_w_abs) * SC_W'(lim_y_hi);
    end

    // ------------------------------------------------------------------
    // Stage five: inclusive bound compare, result registers
    // ------------------------------------------------------------------
    logic in_rect;

    assign in_rect = !r4_w_zero
                  && (r4_lhs_x >= r4_x_lo) && (r4_lhs_x <= r4_x_hi)
                  && (r4_lhs_y >= r4_y_lo) && (r4_lhs_y <= r4_y_hi);

    always_ff @(posedge i_clk) begin
        o_inside_rect <= in_rect;
        o_new_mark    <= r4_prior | in_rect;
    end

`ifndef SYNTHESIS
    // every accepted request yields its result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("request produced no result");

    // no result without a request the fixed latency before
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result without request");

    // a point inside the rectangle is always marked
    a_mark_or: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_inside_rect) |-> o_new_mark)
        else $error("inside point left unmarked");

    // a zero w at the sign fold never ends inside
    a_zero_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && r3_w_zero) |-> ##2 !o_inside_rect)
        else $error("zero w selected");
`endif

endmodule
